// File: sv/mmts_pkg.sv
// shared widths, codes and defaults of the multi-mode task scheduler
`default_nettype none
package mmts_pkg;

	localparam int SLOTS_DEF = 5;

	localparam int CMD_W   = 2;
	localparam int VAL_W   = 16;
	localparam int MODE_W  = 3;
	localparam int GSLOT_W = 4;
	localparam int BEST_W  = 17;

	localparam logic [CMD_W-1:0] CMD_YIELD = 2'd0;
	localparam logic [CMD_W-1:0] CMD_EXIT  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_PRIO  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_SHARE = 2'd3;

	localparam logic [MODE_W-1:0] MODE_RR    = 3'd0;
	localparam logic [MODE_W-1:0] MODE_INDEX = 3'd1;
	localparam logic [MODE_W-1:0] MODE_PRIO  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_SHARE = 3'd3;
	localparam logic [MODE_W-1:0] MODE_SWEEP = 3'd4;

	localparam logic [BEST_W-1:0] PRIO_START = 17'd99999;
	localparam logic [VAL_W-1:0]  TBL_RESET  = 16'd1;

endpackage
`default_nettype wire

// File: sv/mmts_if.sv
// event and grant channel interfaces
`default_nettype none
interface mmts_evt_if;
	import mmts_pkg::*;
	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] cmd;
	logic [VAL_W-1:0] value;
	modport source (output valid, output cmd, output value, input ready);
	modport sink (input valid, input cmd, input value, output ready);
endinterface

interface mmts_grant_if;
	import mmts_pkg::*;
	logic               valid;
	logic               ready;
	logic               grant_valid;
	logic [GSLOT_W-1:0] grant_slot;
	modport source (output valid, output grant_valid, output grant_slot, input ready);
	modport sink (input valid, input grant_valid, input grant_slot, output ready);
endinterface
`default_nettype wire

// File: sv/multi_mode_task_scheduler.sv
// multi-policy slot scheduler built around per-slot table memories
//
//  channel  | direction | payload                    | handshake
//  ---------+-----------+----------------------------+-------------
//  evt      | in        | cmd, value                 | valid/ready
//  grant    | out       | grant_valid, grant_slot    | valid/ready
//  cfg      | in        | cfg_wdata (policy mode)    | cfg_we
//
// set priority / set share: table read, write back, result, in that order
// yield or exit: one scan over the slot memories, one slot a cycle, with the slot
//   reads registered; priority and share modes may scan twice, and sweep mode steps
//   one slot a cycle
// one item at a time; evt.ready is high only while idle
// a finished result waits in the scan result register while grant is stalled
// reset restores the tables through per-slot valid bits, no clearing pass
`default_nettype none
module multi_mode_task_scheduler #(
	parameter int NUM_SLOTS = mmts_pkg::SLOTS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [mmts_pkg::MODE_W-1:0] cfg_wdata,
	mmts_evt_if.sink                       evt,
	mmts_grant_if.source                   grant
);
	import mmts_pkg::*;

	localparam int SW   = $clog2(NUM_SLOTS);
	localparam int CW   = $clog2(NUM_SLOTS + 1);
	localparam int KMAX = 2 * NUM_SLOTS + 2;
	localparam int KW   = $clog2(KMAX + 1);
	localparam logic [SW-1:0] SLOT_LAST = SW'(NUM_SLOTS - 1);
	localparam logic [SW-1:0] SLOT_ONE  = SW'(1);
	localparam logic [SW-1:0] SLOT_ZERO = '0;
	localparam logic [CW-1:0] CNT_ALL   = CW'(NUM_SLOTS);
	localparam logic [CW-1:0] CNT_LIN   = CW'(NUM_SLOTS - 1);
	localparam logic [CW-1:0] CNT_ONE   = CW'(1);
	localparam logic [KW-1:0] K_LAST    = KW'(KMAX - 1);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_WR    = 5'b00010,
		ST_SCAN  = 5'b00100,
		ST_SWEEP = 5'b01000,
		ST_FIN   = 5'b10000
	} state_t;

	state_t state_q;

	logic [MODE_W-1:0]    mode_q;
	logic [SW-1:0]        cur_q;
	logic                 sweep_up_q;
	logic [NUM_SLOTS-1:0] run_q;
	logic [NUM_SLOTS-1:0] ps_vld_q;
	logic [NUM_SLOTS-1:0] cnt_vld_q;

	logic [CMD_W-1:0] cmd_q;
	logic [VAL_W-1:0] value_q;

	// scan engine
	logic [SW-1:0]     p_q;
	logic [CW-1:0]     left_q;
	logic              pass2_q;
	logic [BEST_W-1:0] best_q;
	logic              vld_s1;
	logic [SW-1:0]     slot_s1;
	logic              last_s1;

	// sweep walker
	logic [SW-1:0] pid_q;
	logic          up_q;
	logic [KW-1:0] k_q;

	logic          res_vld_q;
	logic [SW-1:0] res_slot_q;

	logic               ov_q;
	logic               gv_q;
	logic [GSLOT_W-1:0] gs_q;

	// table memories: {priority, share} and served count
	logic [2*VAL_W-1:0] ps_mem [NUM_SLOTS];
	logic [VAL_W-1:0]   cnt_mem [NUM_SLOTS];
	logic [2*VAL_W-1:0] ps_rd_s1;
	logic [VAL_W-1:0]   cnt_rd_s1;
	logic               ps_vld_s1;
	logic               cnt_vld_s1;

	logic [SW-1:0]      rd_addr;
	logic               ps_we;
	logic [2*VAL_W-1:0] ps_wd;
	logic               cnt_we;
	logic [SW-1:0]      cnt_wa;
	logic [VAL_W-1:0]   cnt_wd;

	logic [VAL_W-1:0]  prio_s1;
	logic [VAL_W-1:0]  share_s1;
	logic [VAL_W-1:0]  cnt_s1;
	logic              run_s1;
	logic              hit;
	logic              end_pass;
	logic [BEST_W-1:0] best_nxt;
	logic [SW-1:0]     p_nxt;
	logic [SW-1:0]     cur_nxt;

	logic [SW-1:0] pid_a;
	logic          up_a;
	logic          skip;
	logic          sw_hit;

	logic accept;
	logic out_free;

	assign accept   = evt.valid && evt.ready;
	assign out_free = !ov_q || grant.ready;

	assign evt.ready         = (state_q == ST_IDLE);
	assign grant.valid       = ov_q;
	assign grant.grant_valid = gv_q;
	assign grant.grant_slot  = gs_q;

	assign rd_addr = (state_q == ST_IDLE) ? cur_q : p_q;
	assign p_nxt   = (p_q == SLOT_LAST) ? SLOT_ZERO : p_q + SLOT_ONE;
	assign cur_nxt = (cur_q == SLOT_LAST) ? SLOT_ZERO : cur_q + SLOT_ONE;

	// entries never written read as their reset values
	assign prio_s1  = ps_vld_s1 ? ps_rd_s1[2*VAL_W-1:VAL_W] : TBL_RESET;
	assign share_s1 = ps_vld_s1 ? ps_rd_s1[VAL_W-1:0] : TBL_RESET;
	assign cnt_s1   = cnt_vld_s1 ? cnt_rd_s1 : '0;
	assign run_s1   = run_q[slot_s1];

	always_comb begin
		case (mode_q)
			MODE_RR, MODE_INDEX: hit = vld_s1 && run_s1;
			MODE_PRIO:           hit = vld_s1 && run_s1 && pass2_q
			                           && ({1'b0, prio_s1} == best_q);
			MODE_SHARE:          hit = vld_s1 && run_s1 && (share_s1 > cnt_s1);
			default:             hit = 1'b0;
		endcase
	end

	assign end_pass = vld_s1 && last_s1 && !hit;
	assign best_nxt = (vld_s1 && run_s1 && !pass2_q && ({1'b0, prio_s1} < best_q))
	                  ? {1'b0, prio_s1} : best_q;

	// one step of the ping-pong walk
	always_comb begin
		pid_a = pid_q;
		up_a  = up_q;
		skip  = 1'b0;
		if (up_a) begin
			if (pid_a != SLOT_LAST) begin
				pid_a = pid_a + SLOT_ONE;
			end else begin
				up_a = 1'b0;
			end
		end
		if (!up_a) begin
			if (pid_a != SLOT_ONE) begin
				pid_a = pid_a - SLOT_ONE;
			end else begin
				up_a = 1'b1;
				skip = 1'b1;
			end
		end
	end

	assign sw_hit = !skip && run_q[pid_a];

	// table write ports
	always_comb begin
		ps_we  = 1'b0;
		ps_wd  = {prio_s1, value_q};
		cnt_we = 1'b0;
		cnt_wa = cur_q;
		cnt_wd = VAL_W'(1);
		if (state_q == ST_WR) begin
			ps_we = 1'b1;
			if (cmd_q == CMD_PRIO) begin
				ps_wd = {value_q, share_s1};
			end else begin
				cnt_we = 1'b1;
			end
		end else if (state_q == ST_SCAN && hit && mode_q == MODE_SHARE) begin
			cnt_we = 1'b1;
			cnt_wa = slot_s1;
			cnt_wd = cnt_s1 + VAL_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ps_we) begin
			ps_mem[cur_q] <= ps_wd;
		end
		if (cnt_we) begin
			cnt_mem[cnt_wa] <= cnt_wd;
		end
		ps_rd_s1   <= ps_mem[rd_addr];
		cnt_rd_s1  <= cnt_mem[rd_addr];
		ps_vld_s1  <= ps_vld_q[rd_addr];
		cnt_vld_s1 <= cnt_vld_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= evt.cmd;
			value_q <= evt.value;
		end
		if (state_q == ST_FIN && out_free) begin
			gv_q <= res_vld_q;
			gs_q <= res_vld_q ? GSLOT_W'(res_slot_q) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			mode_q     <= MODE_RR;
			cur_q      <= SLOT_ONE;
			sweep_up_q <= 1'b1;
			run_q      <= {{(NUM_SLOTS-1){1'b1}}, 1'b0};
			ps_vld_q   <= '0;
			cnt_vld_q  <= '0;
			p_q        <= '0;
			left_q     <= '0;
			pass2_q    <= 1'b0;
			best_q     <= PRIO_START;
			vld_s1     <= 1'b0;
			slot_s1    <= '0;
			last_s1    <= 1'b0;
			pid_q      <= '0;
			up_q       <= 1'b0;
			k_q        <= '0;
			res_vld_q  <= 1'b0;
			res_slot_q <= '0;
			ov_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (ov_q && grant.ready) begin
				ov_q <= 1'b0;
			end
			if (ps_we) begin
				ps_vld_q[cur_q] <= 1'b1;
			end
			if (cnt_we) begin
				cnt_vld_q[cnt_wa] <= 1'b1;
			end
			vld_s1 <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						pass2_q <= 1'b0;
						best_q  <= PRIO_START;
						p_q     <= SLOT_ONE;
						left_q  <= CNT_LIN;
						if (evt.cmd == CMD_PRIO || evt.cmd == CMD_SHARE) begin
							state_q <= ST_WR;
						end else begin
							if (evt.cmd == CMD_EXIT) begin
								run_q[cur_q] <= 1'b0;
							end
							case (mode_q)
								MODE_RR: begin
									p_q     <= cur_nxt;
									left_q  <= CNT_ALL;
									state_q <= ST_SCAN;
								end
								MODE_INDEX, MODE_PRIO, MODE_SHARE: begin
									state_q <= ST_SCAN;
								end
								MODE_SWEEP: begin
									pid_q   <= cur_q;
									up_q    <= sweep_up_q;
									k_q     <= '0;
									state_q <= ST_SWEEP;
								end
								default: begin
									res_vld_q <= 1'b0;
									state_q   <= ST_FIN;
								end
							endcase
						end
					end
				end

				ST_WR: begin
					res_vld_q  <= run_q[cur_q];
					res_slot_q <= cur_q;
					state_q    <= ST_FIN;
				end

				ST_SCAN: begin
					best_q <= best_nxt;
					if (hit) begin
						res_vld_q  <= 1'b1;
						res_slot_q <= slot_s1;
						cur_q      <= slot_s1;
						state_q    <= ST_FIN;
					end else if (end_pass) begin
						if (mode_q == MODE_PRIO && !pass2_q) begin
							// second pass: rotate from current for the lowest priority
							pass2_q <= 1'b1;
							p_q     <= cur_nxt;
							left_q  <= CNT_ALL;
						end else if (mode_q == MODE_SHARE && !pass2_q) begin
							// every share used up: restart the counts and rescan
							pass2_q   <= 1'b1;
							cnt_vld_q <= '0;
							p_q       <= SLOT_ONE;
							left_q    <= CNT_LIN;
						end else begin
							res_vld_q <= 1'b0;
							state_q   <= ST_FIN;
						end
					end else if (left_q != '0) begin
						vld_s1  <= 1'b1;
						slot_s1 <= p_q;
						last_s1 <= (left_q == CNT_ONE);
						p_q     <= p_nxt;
						left_q  <= left_q - CNT_ONE;
					end
				end

				ST_SWEEP: begin
					if (sw_hit) begin
						res_vld_q  <= 1'b1;
						res_slot_q <= pid_a;
						cur_q      <= pid_a;
						sweep_up_q <= up_a;
						state_q    <= ST_FIN;
					end else if (k_q == K_LAST) begin
						res_vld_q <= 1'b0;
						state_q   <= ST_FIN;
					end else begin
						pid_q <= pid_a;
						up_q  <= up_a;
						k_q   <= k_q + KW'(1);
					end
				end

				ST_FIN: begin
					if (out_free) begin
						ov_q    <= 1'b1;
						state_q <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire
